// ----- design/sntp_pkg.sv -----
// ----------------------------------------------------------------------------
// sntp_pkg
// Shared types, constants and helpers for the SNTP reply checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sntp_pkg;

  // Packet geometry
  localparam int unsigned PACKET_LENGTH = 48;
  localparam int unsigned CNT_W         = 6;

  // Protocol constants
  localparam logic [31:0] EPOCH_S        = 32'd2208988800;
  localparam logic [19:0] US_PER_S       = 20'd1000000;
  localparam logic [15:0] SERVER_PORT    = 16'd123;
  localparam logic [7:0]  UNSYNC_STRATUM = 8'd16;
  localparam logic [2:0]  MODE_SERVER    = 3'd4;
  localparam logic [2:0]  VERSION_MIN    = 3'd3;
  localparam logic [2:0]  VERSION_MAX    = 3'd4;
  localparam logic [1:0]  LEAP_ALARM     = 2'd3;
  localparam logic [7:0]  KISS_FILL      = 8'h2E;
  localparam logic [7:0]  STRAT_PRIMARY  = 8'd1;
  localparam logic [7:0]  STRAT_KISS     = 8'd0;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_MALFORMED = 2'd1;
  localparam logic [1:0] ST_UNSYNC    = 2'd2;
  localparam logic [1:0] ST_KISS      = 2'd3;

  // Byte positions inside the datagram
  localparam logic [CNT_W-1:0] POS_HEADER  = 6'd0;
  localparam logic [CNT_W-1:0] POS_STRATUM = 6'd1;
  localparam logic [CNT_W-1:0] POS_REFID   = 6'd12;
  localparam logic [CNT_W-1:0] POS_ORIGIN  = 6'd24;
  localparam logic [CNT_W-1:0] POS_RECV    = 6'd32;
  localparam logic [CNT_W-1:0] POS_XMIT    = 6'd40;
  localparam logic [CNT_W-1:0] POS_END     = 6'd48;
  localparam logic [CNT_W-1:0] CNT_FULL    = CNT_W'(PACKET_LENGTH);

  // Divider: 96-bit dividend in six 16-bit digits
  localparam int unsigned DIV_DIGITS = 6;
  localparam int unsigned DIV_CYCLES = 2 * DIV_DIGITS;
  localparam int unsigned DCNT_W     = 4;
  // ceil(2^44 / 15625): exact digit estimate for any 30-bit numerator
  localparam logic [30:0] RECIP_M    = 31'd1125899907;

  // Width of offset/delay intermediate sums
  localparam int unsigned WIDE_W = 68;

  typedef struct packed {
    logic [7:0]         data_byte;
    logic               end_of_packet;
    logic [15:0]        source_port;
    logic signed [63:0] request_time_us;
    logic signed [63:0] arrival_time_us;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [1:0]         leap;
    logic [7:0]         stratum;
    logic [31:0]        reference_id;
    logic               reference_is_address;
    logic signed [63:0] clock_offset;
    logic [62:0]        round_trip;
  } out_item_t;

  // One complete, port-checked packet handed from front to back
  typedef struct packed {
    logic [7:0]         header;
    logic [7:0]         stratum;
    logic [31:0]        refid;
    logic [63:0]        origin;
    logic [63:0]        receive;
    logic [63:0]        transmit;
    logic signed [63:0] t1;
    logic signed [63:0] t4;
  } pkt_t;

  // Replace nonprintable refid characters with fill
  function automatic logic [31:0] clean_refid(input logic [31:0] id, input logic [7:0] fill);
    logic [31:0] r;
    logic [7:0]  c;
    r = '0;
    for (int i = 0; i < 4; i++) begin
      c = id[8*i +: 8];
      if (c < 8'd32 || c > 8'd126) begin
        c = fill;
      end
      r[8*i +: 8] = c;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- design/sntp_front.sv -----
// ----------------------------------------------------------------------------
// sntp_front
// Byte capture: keeps header, stratum, refid and timestamps, screens length
// and source port, and hands complete packets to the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sntp_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_push,
  input  sntp_pkg::in_item_t  in_data,
  output logic                in_full,
  output logic                q_push,
  output sntp_pkg::pkt_t      q_data,
  input  wire                 q_full
);

  logic [sntp_pkg::CNT_W-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic [7:0]  hdr_r, hdr_nxt;
  logic [7:0]  strat_r, strat_nxt;
  logic [31:0] refid_r, refid_nxt;
  logic [63:0] orig_r, orig_nxt;
  logic [63:0] recv_r, recv_nxt;
  logic [63:0] xmit_r, xmit_nxt;
  logic        accept;
  logic        keep;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;
  assign keep    = cnt_r < sntp_pkg::CNT_FULL;
  assign cnt_inc = keep ? cnt_r + 1'b1 : cnt_r;

  // Field capture by byte position
  always_comb begin
    hdr_nxt   = hdr_r;
    strat_nxt = strat_r;
    refid_nxt = refid_r;
    orig_nxt  = orig_r;
    recv_nxt  = recv_r;
    xmit_nxt  = xmit_r;
    if (accept && keep) begin
      if (cnt_r == sntp_pkg::POS_HEADER) begin
        hdr_nxt = in_data.data_byte;
      end else if (cnt_r == sntp_pkg::POS_STRATUM) begin
        strat_nxt = in_data.data_byte;
      end else if (cnt_r >= sntp_pkg::POS_REFID && cnt_r < sntp_pkg::POS_REFID + 6'd4) begin
        refid_nxt = {refid_r[23:0], in_data.data_byte};
      end else if (cnt_r >= sntp_pkg::POS_ORIGIN && cnt_r < sntp_pkg::POS_RECV) begin
        orig_nxt = {orig_r[55:0], in_data.data_byte};
      end else if (cnt_r >= sntp_pkg::POS_RECV && cnt_r < sntp_pkg::POS_XMIT) begin
        recv_nxt = {recv_r[55:0], in_data.data_byte};
      end else if (cnt_r >= sntp_pkg::POS_XMIT && cnt_r < sntp_pkg::POS_END) begin
        xmit_nxt = {xmit_r[55:0], in_data.data_byte};
      end
    end
  end

  // Byte counter, back to zero on the final byte
  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      cnt_nxt = in_data.end_of_packet ? '0 : cnt_inc;
    end
  end

  // Hand off packets of at least full length from the server port
  assign q_push = accept && in_data.end_of_packet &&
                  (cnt_inc == sntp_pkg::CNT_FULL) &&
                  (in_data.source_port == sntp_pkg::SERVER_PORT);

  always_comb begin
    q_data.header   = hdr_nxt;
    q_data.stratum  = strat_nxt;
    q_data.refid    = refid_nxt;
    q_data.origin   = orig_nxt;
    q_data.receive  = recv_nxt;
    q_data.transmit = xmit_nxt;
    q_data.t1       = in_data.request_time_us;
    q_data.t4       = in_data.arrival_time_us;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      hdr_r   <= '0;
      strat_r <= '0;
      refid_r <= '0;
      orig_r  <= '0;
      recv_r  <= '0;
      xmit_r  <= '0;
    end else begin
      cnt_r   <= cnt_nxt;
      hdr_r   <= hdr_nxt;
      strat_r <= strat_nxt;
      refid_r <= refid_nxt;
      orig_r  <= orig_nxt;
      recv_r  <= recv_nxt;
      xmit_r  <= xmit_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- design/sntp_queue.sv -----
// ----------------------------------------------------------------------------
// sntp_queue
// Two-entry packet queue between the capture front and the compute back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sntp_queue (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             push,
  input  sntp_pkg::pkt_t  push_data,
  output logic            full,
  input  wire             pop,
  output sntp_pkg::pkt_t  head,
  output logic            empty
);

  sntp_pkg::pkt_t mem [2];
  logic       wr_r, wr_nxt;
  logic       rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full    = cnt_r == 2'd2;
  assign empty   = cnt_r == 2'd0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_r];

  // Pointer and occupancy update
  always_comb begin
    wr_nxt  = do_push ? ~wr_r : wr_r;
    rd_nxt  = do_pop ? ~rd_r : rd_r;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- design/sntp_back.sv -----
// ----------------------------------------------------------------------------
// sntp_back
// Per-packet checks and arithmetic: origin compare through a reciprocal
// multiply divider, timestamp conversion, offset and delay, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sntp_back (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  q_empty,
  input  sntp_pkg::pkt_t       q_head,
  output logic                 q_pop,
  output logic                 out_empty,
  input  wire                  out_pop,
  output sntp_pkg::out_item_t  out_data
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DIV   = 7'b0000010,
    S_CONV2 = 7'b0000100,
    S_CONV3 = 7'b0001000,
    S_SUM1  = 7'b0010000,
    S_SUM2  = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  localparam int unsigned W = sntp_pkg::WIDE_W;

  state_t state_r, state_nxt;
  sntp_pkg::pkt_t pkt_r;
  logic        neg_r;
  logic [95:0] dv_r;
  logic [19:0] rem_r;
  logic [63:0] quo_r;
  logic [35:0] cur_r;
  logic [15:0] qd_r;
  logic [sntp_pkg::DCNT_W-1:0] dcnt_r;
  logic        orig_ok_r;
  logic signed [54:0] sp_r;
  logic [19:0]        fp_r;
  logic signed [W-1:0] t2_r, a_r, b_r, c_r, e_r, s_r, d_r;
  logic        out_valid_r;
  sntp_pkg::out_item_t out_r, res;
  logic        slot_free;

  logic [63:0] t1_mag;
  logic [35:0] cur_val, qd_mul, rem_full;
  logic [60:0] recip_prod;
  logic [15:0] qd_val;
  logic [63:0] v_val, stamp_val;
  logic [63:0] mul_src;
  logic signed [33:0] sec_diff;
  logic signed [54:0] sp_val;
  logic [51:0] fp_prod;
  logic signed [W-1:0] t1_w, t4_w, t3_w, s_adj, h_val;
  logic [2:0] mode, vn;
  logic [1:0] li;
  logic [7:0] st;

  assign slot_free = !out_valid_r || out_pop;
  assign q_pop     = (state_r == S_IDLE) && !q_empty;
  assign out_empty = !out_valid_r;
  assign out_data  = out_r;

  assign t1_mag = q_head.t1[63] ? (~q_head.t1 + 64'd1) : q_head.t1;
  assign t1_w   = {{(W-64){pkt_r.t1[63]}}, pkt_r.t1};
  assign t4_w   = {{(W-64){pkt_r.t4[63]}}, pkt_r.t4};

  // Division by one million, one 16-bit quotient digit at a time: a first
  // step estimates the digit by reciprocal multiply, a second forms the remainder
  assign cur_val    = {rem_r, dv_r[95:80]};
  assign recip_prod = cur_val[35:6] * sntp_pkg::RECIP_M;
  assign qd_val     = recip_prod[59:44];
  assign qd_mul     = qd_r * sntp_pkg::US_PER_S;
  assign rem_full   = cur_r - qd_mul;

  // Floor of T1 * 2^32 / 1e6, rebased to the NTP epoch
  assign v_val     = neg_r ? (~(quo_r + {63'b0, rem_r != 20'd0}) + 64'd1) : quo_r;
  assign stamp_val = v_val + {sntp_pkg::EPOCH_S, 32'h0};

  // NTP stamp to microseconds, split into seconds and fraction products
  assign mul_src  = (state_r == S_CONV2) ? pkt_r.receive : pkt_r.transmit;
  assign sec_diff = $signed({2'b00, mul_src[63:32]}) - $signed({2'b00, sntp_pkg::EPOCH_S});
  assign sp_val   = sec_diff * $signed({1'b0, sntp_pkg::US_PER_S});
  assign fp_prod  = mul_src[31:0] * sntp_pkg::US_PER_S;
  assign t3_w     = {{(W-55){sp_r[54]}}, sp_r} + {{(W-20){1'b0}}, fp_r};

  // Offset halving toward zero
  assign s_adj = s_r + {{(W-1){1'b0}}, s_r[W-1]};
  assign h_val = s_adj >>> 1;

  assign li   = pkt_r.header[7:6];
  assign vn   = pkt_r.header[5:3];
  assign mode = pkt_r.header[2:0];
  assign st   = pkt_r.stratum;

  // Reply classification and saturation
  always_comb begin
    res = '0;
    if (mode != sntp_pkg::MODE_SERVER || vn < sntp_pkg::VERSION_MIN ||
        vn > sntp_pkg::VERSION_MAX || !orig_ok_r) begin
      res.status = sntp_pkg::ST_MALFORMED;
    end else if (st == sntp_pkg::STRAT_KISS) begin
      res.status       = sntp_pkg::ST_KISS;
      res.leap         = li;
      res.stratum      = st;
      res.reference_id = sntp_pkg::clean_refid(pkt_r.refid, sntp_pkg::KISS_FILL);
    end else if (li == sntp_pkg::LEAP_ALARM || st >= sntp_pkg::UNSYNC_STRATUM) begin
      res.status  = sntp_pkg::ST_UNSYNC;
      res.leap    = li;
      res.stratum = st;
    end else begin
      res.leap    = li;
      res.stratum = st;
      if (st == sntp_pkg::STRAT_PRIMARY) begin
        res.reference_id = sntp_pkg::clean_refid(pkt_r.refid, 8'h00);
      end else begin
        res.reference_id         = pkt_r.refid;
        res.reference_is_address = 1'b1;
      end
      if (pkt_r.transmit == 64'd0) begin
        res.status = sntp_pkg::ST_MALFORMED;
      end else begin
        res.status = sntp_pkg::ST_OK;
        if (h_val[W-1:63] == {(W-63){h_val[63]}}) begin
          res.clock_offset = h_val[63:0];
        end else if (h_val[W-1]) begin
          res.clock_offset = {1'b1, 63'b0};
        end else begin
          res.clock_offset = {1'b0, {63{1'b1}}};
        end
        if (d_r[W-1]) begin
          res.round_trip = '0;
        end else if (|d_r[W-2:63]) begin
          res.round_trip = {63{1'b1}};
        end else begin
          res.round_trip = d_r[62:0];
        end
      end
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (!q_empty) state_nxt = S_DIV;
      S_DIV:   if (dcnt_r == sntp_pkg::DCNT_W'(sntp_pkg::DIV_CYCLES - 1)) state_nxt = S_CONV2;
      S_CONV2: state_nxt = S_CONV3;
      S_CONV3: state_nxt = S_SUM1;
      S_SUM1:  state_nxt = S_SUM2;
      S_SUM2:  state_nxt = S_FIN;
      S_FIN:   if (slot_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        // Packet latch and divider load
        pkt_r  <= q_head;
        dcnt_r <= '0;
        neg_r  <= q_head.t1[63];
        dv_r   <= {t1_mag, 32'h0};
        rem_r  <= '0;
        quo_r  <= '0;
      end
      S_DIV: begin
        if (!dcnt_r[0]) begin
          cur_r <= cur_val;
          qd_r  <= qd_val;
          dv_r  <= {dv_r[79:0], 16'h0};
        end else begin
          rem_r <= rem_full[19:0];
          quo_r <= {quo_r[47:0], qd_r};
        end
        dcnt_r <= dcnt_r + 1'b1;
      end
      S_CONV2: begin
        orig_ok_r <= stamp_val == pkt_r.origin;
        sp_r      <= sp_val;
        fp_r      <= fp_prod[51:32];
      end
      S_CONV3: begin
        t2_r <= t3_w;
        sp_r <= sp_val;
        fp_r <= fp_prod[51:32];
      end
      S_SUM1: begin
        a_r <= t2_r - t1_w;
        b_r <= t3_w - t4_w;
        c_r <= t4_w - t1_w;
        e_r <= t2_r - t3_w;
      end
      S_SUM2: begin
        s_r <= a_r + b_r;
        d_r <= c_r + e_r;
      end
      S_FIN: begin
      end
      default: begin
      end
    endcase
    if (state_r == S_FIN && slot_free) begin
      out_r <= res;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_FIN && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/sntp_reply_checker.sv -----
// Path: a packet's final byte is pushed into the queue; the back end then takes it
//   through divider, conversion, sum and final states into the result register.
// Throughput: one byte per cycle while in_full is low; the back end finishes one
//   packet before it takes the next, and packets of 48 bytes or more stream
//   without stalls while results are taken. Two packets may wait in between.
// Reset: synchronous, active low; clears counters, queue and the result valid flag.
// ----------------------------------------------------------------------------
// sntp_reply_checker
// SNTP reply checker: byte capture front, packet queue, compute back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sntp_reply_checker (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_push,
  input  sntp_pkg::in_item_t   in_data,
  output logic                 in_full,
  output logic                 out_empty,
  input  wire                  out_pop,
  output sntp_pkg::out_item_t  out_data
);

  logic           q_push, q_full, q_pop, q_empty;
  sntp_pkg::pkt_t q_wdata, q_head;

  sntp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_data (in_data),
    .in_full (in_full),
    .q_push  (q_push),
    .q_data  (q_wdata),
    .q_full  (q_full)
  );

  sntp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  sntp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
